>>> rtl/rtpd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the rgb to packed pixel dither unit
// no dependencies

package rtpd_pkg;

    // pixel word width of the target display
    localparam int PIXEL_BITS = 32;

    // pixel result is kept to the display word and then to 32 bits
    localparam logic [31:0] PIX_MASK = (PIXEL_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << PIXEL_BITS) - 64'd1);

    // configuration register indexes
    localparam logic [1:0] REG_RED_FIELD   = 2'd0;
    localparam logic [1:0] REG_GREEN_FIELD = 2'd1;
    localparam logic [1:0] REG_BLUE_FIELD  = 2'd2;

    localparam logic [31:0] RED_FIELD_RST   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_FIELD_RST = 32'h0000_FF00;
    localparam logic [31:0] BLUE_FIELD_RST  = 32'h0000_00FF;

    // full-scale input level, divisor of the scaling step
    localparam int DIV_BASE = 255;

    // 4x4 bayer kernel, already scaled by 16
    localparam logic [7:0] BAYER [16] = '{
        8'd0,   8'd128, 8'd32,  8'd160,
        8'd192, 8'd64,  8'd224, 8'd96,
        8'd48,  8'd176, 8'd16,  8'd144,
        8'd240, 8'd112, 8'd208, 8'd80
    };

    // per channel values derived from a mask
    typedef struct packed {
        logic [4:0]  shift;
        logic [31:0] maxv;
    } chan_cfg_t;

    // load enables of the channel datapath stages
    typedef struct packed {
        logic mul;
        logic est;
        logic fix;
    } stage_en_t;

    // index of the lowest set bit, 31 when no bit is set
    function automatic logic [4:0] low_bit(input logic [31:0] m);
        logic [4:0] s;
        s = 5'd31;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    function automatic chan_cfg_t derive(input logic [31:0] m);
        chan_cfg_t c;
        c.shift = low_bit(m);
        c.maxv  = m >> c.shift;
        return c;
    endfunction

endpackage

>>> rtl/rtpd_cfg.sv
`timescale 1ns / 1ps
// channel mask registers and their registered shift / max values
// depends on rtpd_pkg

module rtpd_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_wdata,
    output rtpd_pkg::chan_cfg_t       red_cfg,
    output rtpd_pkg::chan_cfg_t       green_cfg,
    output rtpd_pkg::chan_cfg_t       blue_cfg
);

    logic [31:0] red_field_reg, green_field_reg, blue_field_reg;
    logic [31:0] red_field_next, green_field_next, blue_field_next;
    rtpd_pkg::chan_cfg_t red_cfg_reg, green_cfg_reg, blue_cfg_reg;

    always_comb begin
        red_field_next   = red_field_reg;
        green_field_next = green_field_reg;
        blue_field_next  = blue_field_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rtpd_pkg::REG_RED_FIELD:   red_field_next   = cfg_wdata;
                rtpd_pkg::REG_GREEN_FIELD: green_field_next = cfg_wdata;
                rtpd_pkg::REG_BLUE_FIELD:  blue_field_next  = cfg_wdata;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // derived values follow the write in the same cycle so they are ready
    // before an item reaches the multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_field_reg   <= rtpd_pkg::RED_FIELD_RST;
            green_field_reg <= rtpd_pkg::GREEN_FIELD_RST;
            blue_field_reg  <= rtpd_pkg::BLUE_FIELD_RST;
            red_cfg_reg     <= rtpd_pkg::derive(rtpd_pkg::RED_FIELD_RST);
            green_cfg_reg   <= rtpd_pkg::derive(rtpd_pkg::GREEN_FIELD_RST);
            blue_cfg_reg    <= rtpd_pkg::derive(rtpd_pkg::BLUE_FIELD_RST);
        end else begin
            red_field_reg   <= red_field_next;
            green_field_reg <= green_field_next;
            blue_field_reg  <= blue_field_next;
            red_cfg_reg     <= rtpd_pkg::derive(red_field_next);
            green_cfg_reg   <= rtpd_pkg::derive(green_field_next);
            blue_cfg_reg    <= rtpd_pkg::derive(blue_field_next);
        end
    end

    assign red_cfg   = red_cfg_reg;
    assign green_cfg = green_cfg_reg;
    assign blue_cfg  = blue_cfg_reg;

endmodule

>>> rtl/rtpd_chan.sv
`timescale 1ns / 1ps
// one color channel: scale by max, add dither bias, divide by 255, place
// depends on rtpd_pkg

module rtpd_chan (
    input  logic                  aclk,
    input  rtpd_pkg::stage_en_t   en,
    input  rtpd_pkg::chan_cfg_t   cfg,
    input  logic [7:0]            chan_val,
    input  logic [7:0]            bias,
    output logic [31:0]           placed
);

    localparam logic [10:0] R1 = 11'(rtpd_pkg::DIV_BASE);
    localparam logic [10:0] R2 = 11'(2 * rtpd_pkg::DIV_BASE);
    localparam logic [10:0] R3 = 11'(3 * rtpd_pkg::DIV_BASE);
    localparam logic [10:0] R4 = 11'(4 * rtpd_pkg::DIV_BASE);

    logic [39:0] prod;
    logic [39:0] x_reg;
    logic [31:0] est_sum;
    logic [31:0] q0_reg;
    logic [10:0] x_lo_reg;
    logic [10:0] rem;
    logic [2:0]  corr;
    logic [31:0] level_reg;

    assign prod = 40'(cfg.maxv) * 40'(chan_val);

    // x / 255 as the sum of x / 256^k, each term floored; falls short by at most 4
    // the sum never exceeds the true quotient, which fits 32 bits
    assign est_sum = x_reg[39:8] + 32'(x_reg[39:16]) + 32'(x_reg[39:24])
                   + 32'(x_reg[39:32]);

    // remainder x - 255*q0 stays below 5*255, so 11 low bits are exact
    assign rem  = x_lo_reg - {q0_reg[2:0], 8'h00} + q0_reg[10:0];
    assign corr = 3'(rem >= R1) + 3'(rem >= R2) + 3'(rem >= R3) + 3'(rem >= R4);

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            x_reg <= prod + 40'(bias);
        end
        if (en.est) begin
            q0_reg   <= est_sum;
            x_lo_reg <= x_reg[10:0];
        end
        if (en.fix) begin
            level_reg <= q0_reg + 32'(corr);
        end
    end

    // level never exceeds max, so the shifted value fits the word
    assign placed = level_reg << cfg.shift;

endmodule

>>> rtl/rgb_to_packed_pixel_dither_unit.sv
`timescale 1ns / 1ps
// top level: ordered dither of an rgb888 color into a packed true-color pixel
// depends on rtpd_pkg, rtpd_cfg, rtpd_chan
//
// channel  | dir | tdata bits (low first)               | tuser
// ---------+-----+--------------------------------------+------
// s_       | in  | color[31:0], dither_pos[35:32], pad  | none
// m_       | out | pixel[31:0]                          | none
// cfg_     | in  | index 0 red field, 1 green field, 2 blue field
//
// one item per clock while m_tready is high; an item passes the stages below in order
// stages: input register, byte split and bias lookup, 32x8 multiply,
// divide estimate, remainder fix, place and or into the output register
// each stage only holds when it is full and the stage after it is held,
// so bubbles close up and input keeps flowing while a result waits until the pipe is full
// aresetn (synchronous) empties the pipe and loads the default masks
// mask writes are registered; derived shift and max are registered with them

module rgb_to_packed_pixel_dither_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // color[31:0], dither_pos[35:32], zeros[39:36]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel[31:0]
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    // stage valid bits, 1 = input register ... 6 = output register
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // payload; the top color byte is not part of the color
    logic [23:0] color_reg;
    logic [3:0]  pos_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, bias_reg;
    logic [31:0] pixel_reg;
    logic [31:0] pixel_next;

    rtpd_pkg::chan_cfg_t red_cfg, green_cfg, blue_cfg;
    rtpd_pkg::stage_en_t chan_en;
    logic [31:0] red_placed, green_placed, blue_placed;

    // hold chain: a stage loads when empty or when the next one moves
    assign en6 = !v6_reg || m_tready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_tready = en1;
    assign m_tvalid = v6_reg;
    assign m_tdata  = pixel_reg;

    assign chan_en.mul = en3;
    assign chan_en.est = en4;
    assign chan_en.fix = en5;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // input register, byte split / kernel lookup and output register
    always_ff @(posedge aclk) begin
        if (en1) begin
            color_reg <= s_tdata[23:0];
            pos_reg   <= s_tdata[35:32];
        end
        if (en2) begin
            red_reg   <= color_reg[7:0];
            green_reg <= color_reg[15:8];
            blue_reg  <= color_reg[23:16];
            bias_reg  <= rtpd_pkg::BAYER[pos_reg];
        end
        if (en6) begin
            pixel_reg <= pixel_next;
        end
    end

    // channels sit in disjoint or overlapping fields; or them like the display does
    assign pixel_next = (red_placed | green_placed | blue_placed) & rtpd_pkg::PIX_MASK;

    rtpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .red_cfg   (red_cfg),
        .green_cfg (green_cfg),
        .blue_cfg  (blue_cfg)
    );

    rtpd_chan u_red (
        .aclk     (aclk),
        .en       (chan_en),
        .cfg      (red_cfg),
        .chan_val (red_reg),
        .bias     (bias_reg),
        .placed   (red_placed)
    );

    rtpd_chan u_green (
        .aclk     (aclk),
        .en       (chan_en),
        .cfg      (green_cfg),
        .chan_val (green_reg),
        .bias     (bias_reg),
        .placed   (green_placed)
    );

    rtpd_chan u_blue (
        .aclk     (aclk),
        .en       (chan_en),
        .cfg      (blue_cfg),
        .chan_val (blue_reg),
        .bias     (bias_reg),
        .placed   (blue_placed)
    );

endmodule

>>> rtl/rtpd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the rgb to packed pixel dither unit, bound to the top
// depends on rgb_to_packed_pixel_dither_unit

module rtpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // when the output side can move, the input side is never blocked
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked with a free output");

    // with no back pressure an accepted item comes out at m_tvalid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready
            ##1 m_tready ##1 m_tready |=> ##1 m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind rgb_to_packed_pixel_dither_unit rtpd_checker u_rtpd_checker (.*);

>>> sim/tb_rgb_to_packed_pixel_dither_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the rgb to packed pixel dither unit
// checks every pixel against its own dither model, with random gaps on both streams
// depends on rtpd_pkg and rgb_to_packed_pixel_dither_unit

module tb_rgb_to_packed_pixel_dither_unit;

    // register index the block must ignore
    localparam logic [1:0] REG_NONE = 2'd3;

    // cycles without any accepted item before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // wait after the last pixel, with margin, for the block to settle
    localparam int SETTLE_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 70;

    // ordered dither bias per kernel position, kernel value times 16
    localparam logic [7:0] DITHER_BIAS [16] = '{
        8'd0,   8'd128, 8'd32,  8'd160,
        8'd192, 8'd64,  8'd224, 8'd96,
        8'd48,  8'd176, 8'd16,  8'd144,
        8'd240, 8'd112, 8'd208, 8'd80
    };

    // expected pixels in order, with the current masks
    class pixel_scoreboard;
        logic [31:0] red_field;
        logic [31:0] green_field;
        logic [31:0] blue_field;
        logic [31:0] pending_pixels[$];
        int          failures;

        function new();
            red_field   = rtpd_pkg::RED_FIELD_RST;
            green_field = rtpd_pkg::GREEN_FIELD_RST;
            blue_field  = rtpd_pkg::BLUE_FIELD_RST;
            failures    = 0;
        endfunction

        function void set_mask(logic [1:0] idx, logic [31:0] value);
            case (idx)
                rtpd_pkg::REG_RED_FIELD:   red_field   = value;
                rtpd_pkg::REG_GREEN_FIELD: green_field = value;
                rtpd_pkg::REG_BLUE_FIELD:  blue_field  = value;
                default: ;
            endcase
        endfunction

        // one channel scaled to the field width and placed at the field position
        function logic [63:0] channel_field(logic [31:0] mask, logic [7:0] level,
                                            logic [7:0] bias);
            int          sh;
            logic [63:0] top;
            logic [63:0] scaled;
            if (mask == 32'd0) begin
                return 64'd0;
            end
            sh = 0;
            while (sh < 31 && !mask[sh]) begin
                sh++;
            end
            top    = 64'(mask >> sh);
            scaled = (top * 64'(level) + 64'(bias)) / 64'd255;
            return scaled << sh;
        endfunction

        function void note_input(logic [31:0] color, logic [3:0] pos);
            logic [7:0]  bias;
            logic [63:0] pix;
            bias = DITHER_BIAS[pos];
            pix  = channel_field(red_field,   color[7:0],   bias)
                 | channel_field(green_field, color[15:8],  bias)
                 | channel_field(blue_field,  color[23:16], bias);
            pending_pixels.push_back(pix[31:0]);
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending_pixels.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected pixel %h at %0t", got, $realtime);
                end
                return;
            end
            want = pending_pixels.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("pixel mismatch at %0t: expected %h, got %h",
                             $realtime, want, got);
                end
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        // leftover expectations count as failures
        function int closing_failures();
            if (pending_pixels.size() != 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0d pixels never arrived", pending_pixels.size());
                end
            end
            return failures;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = 40'd0;     // color[31:0], dither_pos[35:32], zeros[39:36]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // pixel[31:0]
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_wdata = 32'd0;

    pixel_scoreboard sb;
    bit              no_gaps = 1'b0;  // phases that run both streams flat out
    int              ready_hold = 0;
    int              stall_len;
    int              idle_cycles = 0;

    rgb_to_packed_pixel_dither_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // gap length: mostly none, often short, now and then a long one; none when no_gaps is set
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // byte biased toward the ends of its range
    function automatic logic [7:0] edge_byte();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'hFE;
            default: return 8'($urandom);
        endcase
    endfunction

    // random contiguous field anywhere in the word
    function automatic logic [31:0] random_field_mask();
        int          w;
        int          lsb;
        logic [63:0] ones;
        w    = $urandom_range(1, 32);
        lsb  = $urandom_range(0, 32 - w);
        ones = (64'd1 << w) - 64'd1;
        return 32'(ones << lsb);
    endfunction

    // result side: check every accepted pixel, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            stall_len = pick_gap();
            if (stall_len == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= stall_len - 1;
            end
        end
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one item after a random gap and hold it until it is taken
    task automatic send_item(input logic [31:0] color, input logic [3:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pos, color};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(color, pos);
    endtask

    // stop offering, let every pixel come out and the pipe run empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register write; it lands at the next edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_mask(idx, value);
    endtask

    // new masks, plus a junk write to the unused index that must change nothing
    task automatic load_masks(input logic [31:0] red, input logic [31:0] green,
                              input logic [31:0] blue);
        write_reg(rtpd_pkg::REG_RED_FIELD, red);
        write_reg(REG_NONE, $urandom);
        write_reg(rtpd_pkg::REG_GREEN_FIELD, green);
        write_reg(rtpd_pkg::REG_BLUE_FIELD, blue);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        logic [31:0] color;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 7) begin
                color = $urandom;
            end else begin
                color = {edge_byte(), edge_byte(), edge_byte(), edge_byte()};
            end
            send_item(color, 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic run_phase(input logic [31:0] red, input logic [31:0] green,
                             input logic [31:0] blue, input int count);
        drain();
        load_masks(red, green, blue);
        run_random(count);
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset masks: every kernel position with a spread of colors
        for (int p = 0; p < 16; p++) begin
            send_item({8'(p * 16), 8'(p * 17), 8'(255 - p * 17), 8'(p * 13)}, 4'(p));
        end
        // full scale with no bias, black at the last kernel position
        send_item(32'hFFFF_FFFF, 4'd0);
        send_item(32'h0000_0000, 4'd15);
        // position 1 is plain rounding of a mid level
        send_item(32'h0080_8080, 4'd1);
        // top byte is not part of the color
        send_item(32'hFF00_0000, 4'd15);
        send_item(32'h0001_FE01, 4'd12);
        run_random(ITEMS_PER_PHASE);

        // rgb565
        run_phase(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, ITEMS_PER_PHASE);
        // zero masks give a zero channel
        run_phase(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 30);
        // widest field, topmost single bit, bottom single bit
        run_phase(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, ITEMS_PER_PHASE);
        // masks with holes
        run_phase(32'hA5A5_0000, 32'h0000_F0F0, 32'h8000_0001, ITEMS_PER_PHASE);
        // swapped channel order, both streams without gaps
        no_gaps = 1'b1;
        run_phase(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, ITEMS_PER_PHASE);
        no_gaps = 1'b0;
        // 10 bits per channel
        run_phase(32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF, ITEMS_PER_PHASE);
        // random contiguous fields, possibly overlapping
        run_phase(random_field_mask(), random_field_mask(), random_field_mask(),
                  ITEMS_PER_PHASE);
        // arbitrary bit patterns
        run_phase($urandom, $urandom, $urandom, ITEMS_PER_PHASE);
        // back to the reset values
        run_phase(rtpd_pkg::RED_FIELD_RST, rtpd_pkg::GREEN_FIELD_RST,
                  rtpd_pkg::BLUE_FIELD_RST, 40);

        drain();
        if (sb.closing_failures() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
